/* sv/w3sf_pkg.sv */
// ----------------------------------------------------------------------------
// w3sf_pkg: shared types and constants of the weighted 3x3 smoothing filter
// Payload structs, the queue entry passed from front to back, field widths
// and the constants of the divide-by-ten step.
// ----------------------------------------------------------------------------
package w3sf_pkg;

  // Frame geometry limits.
  localparam int unsigned MAX_WIDTH = 256;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W   = 9;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned ROW_W     = HEIGHT_W + 1;
  localparam int unsigned PIX_W     = 8;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = HEIGHT_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);
  localparam logic [WIDTH_W-1:0]     RESET_WIDTH      = WIDTH_W'(256);
  localparam logic [HEIGHT_W-1:0]    RESET_HEIGHT     = HEIGHT_W'(256);
  localparam logic [WIDTH_W-1:0]     MIN_WIDTH        = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]     LIMIT_WIDTH      = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0]    MIN_HEIGHT       = HEIGHT_W'(3);

  // Item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Weighted sum and divide by ten through a reciprocal multiply.
  // Exact for every sum up to ten times the largest pixel.
  localparam int unsigned SUM_W       = $clog2(10 * 255 + 1);
  localparam int unsigned DIV10_SHIFT = 16;
  localparam int unsigned DIV10_MULT  = (1 << DIV10_SHIFT) / 10 + 1;
  localparam int unsigned MULT_W      = $clog2(DIV10_MULT + 1);
  localparam int unsigned PROD_W      = SUM_W + MULT_W;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item.
  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } w3sf_in_t;

  // Result item.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } w3sf_out_t;

  // One pipeline advance, as classified by the front.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] px;
    logic             emit;
    logic             interior;
    logic             last;
  } w3sf_op_t;

endpackage

/* sv/weighted_3x3_smoothing_filter.sv */
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter: raster 3x3 weighted smoothing filter
// Interior pixels become (eight neighbours + 2 x centre) / 10; border pixels
// pass through. Results trail the input by one row plus one pixel.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                               Direction  Item
//  -------  ------------------------------------  ---------  ------------------
//  in       in_valid_i, in_stall_o, in_data_i     sink       cmd, pixel_in
//  out      out_valid_o, out_stall_i, out_data_o  source     pixel_out, frame_last
//  cfg      cfg_we_i, cfg_index_i, cfg_data_i     sink       frame_width, height
//
// One item is taken per cycle while the queue has room.
// Results pass the queue, the read, sum and divide stages and the output register.
// Reset clears positions and window and loads the reset configuration; the line
// stores are not cleared and need no clearing pass.
// out_stall_i holds the back; a four-entry queue absorbs items, and in_stall_o
// rises only when that queue is full.
module weighted_3x3_smoothing_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  w3sf_pkg::w3sf_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output w3sf_pkg::w3sf_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [w3sf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [w3sf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic               accept;
  logic               push, q_full, q_valid, pop;
  w3sf_pkg::w3sf_op_t push_op, head_op;

  // Input items are taken whenever the queue has room.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Front: configuration and raster positions.
  w3sf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .op_o        (push_op)
  );

  // Queue between front and back.
  w3sf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  // Back: stores, window, arithmetic and output register.
  w3sf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/w3sf_front.sv */
// ----------------------------------------------------------------------------
// w3sf_front: configuration registers and raster position tracking
// Holds the frame size and the input and result positions, classifies each
// accepted item and hands every pipeline advance to the queue.
// ----------------------------------------------------------------------------
module w3sf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [w3sf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [w3sf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             accept_i,
  input  w3sf_pkg::w3sf_in_t               in_data_i,
  output logic                             push_o,
  output w3sf_pkg::w3sf_op_t               op_o
);

  logic [w3sf_pkg::WIDTH_W-1:0]  frame_width_q;
  logic [w3sf_pkg::HEIGHT_W-1:0] frame_height_q;
  logic [w3sf_pkg::COL_W-1:0]    in_col_q, in_col_d;
  logic [w3sf_pkg::ROW_W-1:0]    in_row_q, in_row_d;
  logic [w3sf_pkg::COL_W-1:0]    out_col_q, out_col_d;
  logic [w3sf_pkg::ROW_W-1:0]    out_row_q, out_row_d;

  logic [w3sf_pkg::WIDTH_W-1:0]  eff_w;
  logic [w3sf_pkg::HEIGHT_W-1:0] eff_h;
  logic [w3sf_pkg::ROW_W-1:0]    eff_h_ext;
  logic                          wrap0, wrap1, out_wrap;
  logic [w3sf_pkg::COL_W-1:0]    ic0;
  logic [w3sf_pkg::ROW_W-1:0]    ir0;
  logic [w3sf_pkg::WIDTH_W-1:0]  ic1;
  logic [w3sf_pkg::WIDTH_W-1:0]  oc1;
  logic [w3sf_pkg::ROW_W:0]      or1;
  logic                          row_live, flush, adv, due, emit;
  logic                          interior, last;

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= w3sf_pkg::RESET_WIDTH;
      frame_height_q <= w3sf_pkg::RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        w3sf_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[w3sf_pkg::WIDTH_W-1:0];
        w3sf_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame size as used: width clamped between 3 and the line store, height at least 3.
  always_comb begin
    if (frame_width_q < w3sf_pkg::MIN_WIDTH) begin
      eff_w = w3sf_pkg::MIN_WIDTH;
    end else if (frame_width_q > w3sf_pkg::LIMIT_WIDTH) begin
      eff_w = w3sf_pkg::LIMIT_WIDTH;
    end else begin
      eff_w = frame_width_q;
    end
    eff_h     = (frame_height_q < w3sf_pkg::MIN_HEIGHT) ? w3sf_pkg::MIN_HEIGHT : frame_height_q;
    eff_h_ext = {1'b0, eff_h};
  end

  // Classify the item and work out the next positions.
  always_comb begin
    flush    = (in_data_i.cmd == w3sf_pkg::CMD_FLUSH);
    wrap0    = ({1'b0, in_col_q} >= eff_w);
    ic0      = wrap0 ? '0 : in_col_q;
    ir0      = wrap0 ? in_row_q + w3sf_pkg::ROW_W'(1) : in_row_q;
    row_live = (ir0 < eff_h_ext);
    ic1      = {1'b0, ic0} + w3sf_pkg::WIDTH_W'(1);
    wrap1    = (ic1 >= eff_w);
    due      = (ir0 >= w3sf_pkg::ROW_W'(2)) ||
               ((ir0 == w3sf_pkg::ROW_W'(1)) && (ic0 != '0));

    in_col_d = ic0;
    in_row_d = ir0;
    if (flush) begin
      adv = !row_live;
      emit = adv;
      if (adv) begin
        in_col_d = wrap1 ? '0 : ic1[w3sf_pkg::COL_W-1:0];
      end
    end else begin
      adv = row_live;
      emit = adv && due;
      if (adv) begin
        in_col_d = wrap1 ? '0 : ic1[w3sf_pkg::COL_W-1:0];
        in_row_d = wrap1 ? ir0 + w3sf_pkg::ROW_W'(1) : ir0;
      end
    end

    // Result position: border test, end of frame and advance.
    or1      = {1'b0, out_row_q} + (w3sf_pkg::ROW_W + 1)'(1);
    oc1      = {1'b0, out_col_q} + w3sf_pkg::WIDTH_W'(1);
    interior = (out_row_q != '0) && (or1 < {1'b0, eff_h_ext}) &&
               (out_col_q != '0) && (oc1 < eff_w);
    last     = (or1 >= {1'b0, eff_h_ext}) && (oc1 >= eff_w);
    out_wrap = (oc1 >= eff_w);

    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (emit) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_wrap) begin
        out_col_d = '0;
        out_row_d = out_row_q + w3sf_pkg::ROW_W'(1);
      end else begin
        out_col_d = oc1[w3sf_pkg::COL_W-1:0];
      end
    end
  end

  // Position registers move on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Every advance goes to the back; dropped pixels and early flushes do not.
  assign push_o       = accept_i && adv;
  assign op_o.col      = ic0;
  assign op_o.out_col  = out_col_q;
  assign op_o.px       = flush ? '0 : in_data_i.pixel_in;
  assign op_o.emit     = emit;
  assign op_o.interior = interior;
  assign op_o.last     = last;

endmodule

/* sv/w3sf_queue.sv */
// ----------------------------------------------------------------------------
// w3sf_queue: short queue between front and back
// A small circular buffer of classified advances so that the front keeps
// taking items while the back waits on its output.
// ----------------------------------------------------------------------------
module w3sf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  w3sf_pkg::w3sf_op_t op_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output w3sf_pkg::w3sf_op_t op_o
);

  w3sf_pkg::w3sf_op_t               entry_q [w3sf_pkg::QUEUE_DEPTH];
  logic [w3sf_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [w3sf_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == w3sf_pkg::QCNT_W'(w3sf_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  // Fill count follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + w3sf_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - w3sf_pkg::QCNT_W'(1);
    end
  end

  // Pointers wrap naturally at the power-of-two depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + w3sf_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + w3sf_pkg::QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

/* sv/w3sf_back.sv */
// ----------------------------------------------------------------------------
// w3sf_back: line stores, 3x3 window and arithmetic
// Reads the two line stores, shifts the window, writes the stores back,
// forms the weighted sum, divides by ten and holds the result item.
// ----------------------------------------------------------------------------
module w3sf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  w3sf_pkg::w3sf_op_t    q_op_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output w3sf_pkg::w3sf_out_t   out_data_o
);

  logic [w3sf_pkg::PIX_W-1:0] upper_mem  [w3sf_pkg::MAX_WIDTH];
  logic [w3sf_pkg::PIX_W-1:0] middle_mem [w3sf_pkg::MAX_WIDTH];
  logic [w3sf_pkg::PIX_W-1:0] window_q   [3][3];

  logic                       en;

  // Read stage.
  logic                       r1_valid_q;
  w3sf_pkg::w3sf_op_t         r1_op_q;
  logic [w3sf_pkg::PIX_W-1:0] up_rd_q, mid_rd_q, upo_rd_q;
  logic                       fwd_col_q, fwd_out_q;
  logic [w3sf_pkg::PIX_W-1:0] fwd_mid_q, fwd_px_q;
  logic [w3sf_pkg::PIX_W-1:0] up_eff, mid_eff, pass_val;

  // Sum stage.
  logic                       r2_valid_q, r2_interior_q, r2_last_q;
  logic [w3sf_pkg::PIX_W-1:0] r2_pass_q;
  logic [w3sf_pkg::SUM_W-1:0] win_sum;

  // Divide stage.
  logic                       r3_valid_q, r3_interior_q, r3_last_q;
  logic [w3sf_pkg::PIX_W-1:0] r3_pass_q;
  logic [w3sf_pkg::SUM_W-1:0] r3_sum_q;
  logic [w3sf_pkg::PROD_W-1:0] quot_prod;

  // Output register.
  logic                       out_valid_q;
  w3sf_pkg::w3sf_out_t        out_data_q;

  // The whole back moves together whenever the output slot frees up.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  // Line store reads: both stores at the input column, upper also at the
  // result column.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      up_rd_q  <= upper_mem[q_op_i.col];
      mid_rd_q <= middle_mem[q_op_i.col];
      upo_rd_q <= upper_mem[q_op_i.out_col];
    end
  end

  // Line store writes: middle moves up, the new pixel enters middle.
  always_ff @(posedge clk_i) begin
    if (en && r1_valid_q) begin
      upper_mem[r1_op_q.col]  <= mid_eff;
      middle_mem[r1_op_q.col] <= r1_op_q.px;
    end
  end

  // Forwarding from the item that writes the stores in the same cycle.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      r1_op_q   <= q_op_i;
      fwd_col_q <= r1_valid_q && (r1_op_q.col == q_op_i.col);
      fwd_out_q <= r1_valid_q && (r1_op_q.col == q_op_i.out_col);
      fwd_mid_q <= mid_eff;
      fwd_px_q  <= r1_op_q.px;
    end
  end

  // Store contents as seen by this item, and the border pass-through value,
  // which is the upper store at the result column after this item's write.
  always_comb begin
    up_eff  = fwd_col_q ? fwd_mid_q : up_rd_q;
    mid_eff = fwd_col_q ? fwd_px_q  : mid_rd_q;
    if (r1_op_q.out_col == r1_op_q.col) begin
      pass_val = mid_eff;
    end else if (fwd_out_q) begin
      pass_val = fwd_mid_q;
    end else begin
      pass_val = upo_rd_q;
    end
  end

  // Window shifts left and takes the new right column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          window_q[r][k] <= '0;
        end
      end
    end else if (en && r1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        window_q[r][0] <= window_q[r][1];
        window_q[r][1] <= window_q[r][2];
      end
      window_q[0][2] <= up_eff;
      window_q[1][2] <= mid_eff;
      window_q[2][2] <= r1_op_q.px;
    end
  end

  // Weighted sum: all nine taps plus the centre once more.
  always_comb begin
    win_sum = w3sf_pkg::SUM_W'(window_q[1][1]);
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        win_sum = win_sum + w3sf_pkg::SUM_W'(window_q[r][k]);
      end
    end
  end

  // Divide by ten as a multiply by the scaled reciprocal.
  assign quot_prod = w3sf_pkg::PROD_W'(r3_sum_q) * w3sf_pkg::PROD_W'(w3sf_pkg::DIV10_MULT);

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_interior_q <= r1_op_q.interior;
      r2_last_q     <= r1_op_q.last;
      r2_pass_q     <= pass_val;
      r3_interior_q <= r2_interior_q;
      r3_last_q     <= r2_last_q;
      r3_pass_q     <= r2_pass_q;
      r3_sum_q      <= win_sum;
      if (r3_valid_q) begin
        out_data_q.pixel_out  <= r3_interior_q ?
            quot_prod[w3sf_pkg::DIV10_SHIFT +: w3sf_pkg::PIX_W] : r3_pass_q;
        out_data_q.frame_last <= r3_last_q;
      end
    end
  end

  // Stage valid bits; only result-bearing advances go past the read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q  <= 1'b0;
      r2_valid_q  <= 1'b0;
      r3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      r1_valid_q  <= q_valid_i;
      r2_valid_q  <= r1_valid_q && r1_op_q.emit;
      r3_valid_q  <= r2_valid_q;
      out_valid_q <= r3_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/sv/weighted_3x3_smoothing_filter_test.sv */
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter_test: self-checking bench of the 3x3 smoother
// Streams raster frames of random and extreme sizes through the filter, with
// flush noise, dropped pixels and mid-frame size changes. An item-level
// predictor computes each expected result as items are accepted, and a monitor
// compares results field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module weighted_3x3_smoothing_filter_test;
  import w3sf_pkg::*;

  localparam int unsigned DIVISOR       = 10;
  localparam int unsigned CENTER_WEIGHT = 2;
  localparam int unsigned IDLE_PCT      = 23;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam int unsigned RUN_LIMIT     = 4_000_000;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = CFG_INDEX_W'(3);

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  w3sf_in_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  w3sf_out_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  w3sf_in_t    pending_pixels[$];
  w3sf_out_t   expected_pixels[$];
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  logic        quiet;

  // Predictor copy of the configuration, line stores, window and positions.
  logic [WIDTH_W-1:0]  width_reg  = RESET_WIDTH;
  logic [HEIGHT_W-1:0] height_reg = RESET_HEIGHT;
  logic [PIX_W-1:0]    upper_row  [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0]    middle_row [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0]    window     [3][3]      = '{default: '{default: '0}};
  int unsigned         in_col  = 0;
  int unsigned         in_row  = 0;
  int unsigned         out_col = 0;
  int unsigned         out_row = 0;

  weighted_3x3_smoothing_filter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock and a single reset pulse at the start of the run.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Shifts the window left, loads the new right column and updates the stores.
  function automatic void shift_window(logic [PIX_W-1:0] px);
    int unsigned c;
    c = (in_col < MAX_WIDTH) ? in_col : 0;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2]  = upper_row[c];
    window[1][2]  = middle_row[c];
    window[2][2]  = px;
    upper_row[c]  = middle_row[c];
    middle_row[c] = px;
  endfunction

  // Forms the result at the output position and moves that position on.
  function automatic w3sf_out_t next_result(int unsigned w, int unsigned h);
    w3sf_out_t   res;
    int unsigned sum;
    bit          last;
    sum = 0;
    if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          sum += window[r][k];
        end
      end
      sum += (CENTER_WEIGHT - 1) * window[1][1];
      res.pixel_out = PIX_W'(sum / DIVISOR);
    end else begin
      res.pixel_out = (out_col < MAX_WIDTH) ? upper_row[out_col] : '0;
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.frame_last = last;
    if (last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  // Applies one accepted item; returns 1 when it produces a result.
  function automatic bit smooth_item(w3sf_in_t item, output w3sf_out_t res);
    int unsigned w;
    int unsigned h;
    bit          due;
    w = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
        ((width_reg > LIMIT_WIDTH) ? LIMIT_WIDTH : width_reg);
    h = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;
    res = '0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (item.cmd == CMD_PIXEL) begin
      // Pixels past the end of the frame are dropped.
      if (in_row >= h) return 1'b0;
      shift_window(item.pixel_in);
      due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!due) return 1'b0;
      res = next_result(w, h);
      return 1'b1;
    end
    // Flushes only count once the frame's pixels are all in.
    if (in_row < h) return 1'b0;
    shift_window('0);
    in_col++;
    if (in_col >= w) in_col = 0;
    res = next_result(w, h);
    return 1'b1;
  endfunction

  // Register writes reach the predictor at the same edge as the block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_reg  = cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Long stretches without any idling on either side.
  assign quiet = (cycle_count % 1500) >= 1100;

  // Driver: predicts each accepted item and presents the next pending one.
  always @(posedge clk) begin : drive_items
    w3sf_out_t res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        items_accepted++;
        if (smooth_item(in_item, res)) expected_pixels.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_item  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    w3sf_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                    out_item.pixel_out, out_item.frame_last));
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out got %0d, expected %0d",
                                      out_item.pixel_out, want.pixel_out));
          if (out_item.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last got %0d, expected %0d",
                                      out_item.frame_last, want.frame_last));
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic queue_item(logic cmd, logic [PIX_W-1:0] px);
    w3sf_in_t item;
    item.cmd      = cmd;
    item.pixel_in = px;
    pending_pixels.push_back(item);
    items_queued++;
  endtask

  // Queues a whole frame with flush noise, a few dropped pixels and the drain.
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned noise_pct);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) queue_item(CMD_FLUSH, PIX_W'($urandom));
      queue_item(CMD_PIXEL, PIX_W'($urandom));
    end
    repeat ($urandom_range(0, 2)) queue_item(CMD_PIXEL, PIX_W'($urandom));
    repeat (w + 1 + $urandom_range(0, 1)) queue_item(CMD_FLUSH, PIX_W'($urandom));
  endtask

  // Waits until every item is in and every result out, then lets the pipe settle.
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus: directed frames first, then random frames and sizes.
  initial begin
    int unsigned random_items;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned frame_w;
    int unsigned frame_h;
    random_items = 0;
    frame_w      = 3;
    frame_h      = 3;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Smallest frame from sizes below the minimum, alternating extremes,
    // a flush inside the frame and a pixel after its end.
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 2);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) queue_item(CMD_FLUSH, 8'hFF);
      queue_item(CMD_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    end
    queue_item(CMD_PIXEL, 8'h5A);
    repeat (4) queue_item(CMD_FLUSH, 8'h00);

    // Saturated frame: the interior sum stays exact at its maximum.
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 0);
    repeat (9) queue_item(CMD_PIXEL, 8'hFF);
    repeat (4) queue_item(CMD_FLUSH, 8'hFF);

    // Width and height shrink part way through the first row.
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 4);
    repeat (6) queue_item(CMD_PIXEL, PIX_W'($urandom));
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 5);
    write_reg(CFG_FRAME_HEIGHT, 3);
    repeat (12) queue_item(CMD_PIXEL, PIX_W'($urandom));
    repeat (6) queue_item(CMD_FLUSH, PIX_W'($urandom));

    // Tallest height, cut down below the current row so the frame ends at once.
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (12) queue_item(CMD_PIXEL, PIX_W'($urandom));
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 3);
    repeat (2) queue_item(CMD_FLUSH, PIX_W'($urandom));

    // Widest row, with writes to unmapped indexes that must change nothing;
    // the width then drops to the minimum two pixels into the second row.
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, MAX_WIDTH);
    write_reg(CFG_FRAME_HEIGHT, 0);
    write_reg(CFG_UNMAPPED_LO, 5);
    write_reg(CFG_UNMAPPED_HI, 16'hFFFF);
    write_reg(CFG_FRAME_WIDTH, 16'h01FF);
    repeat (MAX_WIDTH + 2) queue_item(CMD_PIXEL, PIX_W'($urandom));
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 3);
    repeat (4) queue_item(CMD_PIXEL, PIX_W'($urandom));
    repeat (4) queue_item(CMD_FLUSH, PIX_W'($urandom));

    // Random small frames, some back to back and some after new sizes.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items == 0 || $urandom_range(1) == 1) begin
        wait_idle();
        raw_w = $urandom_range(0, 14);
        raw_h = $urandom_range(0, 6);
        write_reg(CFG_FRAME_WIDTH, ($urandom & 32'hFE00) | raw_w);
        write_reg(CFG_FRAME_HEIGHT, raw_h);
        frame_w = (raw_w < 3) ? 3 : raw_w;
        frame_h = (raw_h < 3) ? 3 : raw_h;
      end
      queue_frame(frame_w, frame_h, 6);
      random_items += frame_w * frame_h;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
